### hw/rtl/fvf_pkg.sv
`default_nettype none

package fvf_pkg;

    // Frame layout: eight payload bytes, then the CRC low and high bytes.
    localparam int FrameLen   = 10;
    localparam int PayloadLen = 8;

    // CRC-16/MODBUS: reflected polynomial, all-ones start, no final inversion.
    localparam logic [15:0] CrcInit = 16'hFFFF;
    localparam logic [15:0] CrcPoly = 16'hA001;

    // Byte position within a frame.
    typedef logic [3:0] fvf_idx_t;

    localparam fvf_idx_t IdxCrcLo = fvf_idx_t'(PayloadLen);
    localparam fvf_idx_t IdxLast  = fvf_idx_t'(FrameLen - 1);

    // One input item; value_a sits in the low bits so it is sent first.
    typedef struct packed {
        logic [15:0] value_d;
        logic [15:0] value_c;
        logic [15:0] value_b;
        logic [15:0] value_a;
    } fvf_item_t;

    // Shift one byte into the CRC, least significant bit first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CrcPoly;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/fvf_in_buf.sv
`default_nettype none

// Input holding register: takes one item and keeps it until the serializer
// picks it up, so a new transfer can land while a frame is still going out.
module fvf_in_buf (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [15:0]        s_value_a,
    input  wire logic [15:0]        s_value_b,
    input  wire logic [15:0]        s_value_c,
    input  wire logic [15:0]        s_value_d,
    output logic                    buf_valid,
    input  wire logic               buf_take,
    output fvf_pkg::fvf_item_t      buf_item
);

    logic               full_reg;
    logic               full_next;
    fvf_pkg::fvf_item_t item_reg;

    assign s_ready   = !full_reg;
    assign buf_valid = full_reg;
    assign buf_item  = item_reg;

    // The buffer fills on an input transfer and empties when the item is taken.
    always_comb begin
        full_next = full_reg;
        if (s_valid && s_ready) begin
            full_next = 1'b1;
        end else if (buf_take) begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else begin
            full_reg <= full_next;
        end
    end

    // Payload capture needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.value_a <= s_value_a;
            item_reg.value_b <= s_value_b;
            item_reg.value_c <= s_value_c;
            item_reg.value_d <= s_value_d;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/fvf_serializer.sv
`default_nettype none

// Frame serializer: sends the payload one byte per cycle unless stalled, folds
// each payload byte into the running CRC as it goes, then appends both CRC bytes.
module fvf_serializer (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               buf_valid,
    output logic                    buf_take,
    input  wire fvf_pkg::fvf_item_t buf_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_frame_byte,
    output logic                    m_last_byte
);

    logic              active_reg;
    logic              active_next;
    logic [63:0]       word_reg;
    logic [63:0]       word_next;
    logic [15:0]       crc_reg;
    logic [15:0]       crc_next;
    fvf_pkg::fvf_idx_t idx_reg;
    fvf_pkg::fvf_idx_t idx_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        out_byte_reg;
    logic [7:0]        out_byte_next;
    logic              out_last_reg;
    logic              out_last_next;
    logic              out_free;
    logic              advance;
    logic              at_last;

    assign m_valid      = out_valid_reg;
    assign m_frame_byte = out_byte_reg;
    assign m_last_byte  = out_last_reg;

    // During a frame, a byte moves into the output register whenever that register is free.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = active_reg && out_free;
    assign at_last  = (idx_reg == fvf_pkg::IdxLast);

    // A new item is loaded when idle or as the last byte of a frame moves out.
    assign buf_take = buf_valid && (!active_reg || (advance && at_last));

    always_comb begin
        active_next    = active_reg;
        word_next      = word_reg;
        crc_next       = crc_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (out_free) begin
            out_valid_next = 1'b0;
        end

        // Pick the next frame byte; payload bytes also update the CRC.
        if (advance) begin
            out_valid_next = 1'b1;
            out_last_next  = at_last;
            idx_next       = idx_reg + fvf_pkg::fvf_idx_t'(1);
            priority if (idx_reg < fvf_pkg::IdxCrcLo) begin
                out_byte_next = word_reg[7:0];
                word_next     = word_reg >> 8;
                crc_next      = fvf_pkg::crc_feed(crc_reg, word_reg[7:0]);
            end else if (idx_reg == fvf_pkg::IdxCrcLo) begin
                out_byte_next = crc_reg[7:0];
            end else begin
                out_byte_next = crc_reg[15:8];
            end
            if (at_last) begin
                active_next = 1'b0;
            end
        end

        // Start a fresh frame from the input buffer.
        if (buf_take) begin
            active_next = 1'b1;
            word_next   = buf_item;
            crc_next    = fvf_pkg::CrcInit;
            idx_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge aclk) begin
        word_reg     <= word_next;
        crc_reg      <= crc_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire

### hw/rtl/four_value_frame_with_crc16.sv
`default_nettype none

// Turns each input transfer of four 16-bit values into a 10-byte frame: the
// values in order, each low byte first, followed by a CRC-16/MODBUS over those
// eight bytes (low byte first), with m_last_byte set on the final CRC byte.
// The output emits one byte per cycle while m_ready stays high; the serializer
// folds each payload byte into the CRC as it sends that byte. A one-item input
// buffer takes the next transfer while a frame is still being sent, and a frame
// whose item is already buffered follows the previous one with no gap. An item
// passes from the input buffer register through the serializer's word register
// into its output register before the first byte appears at the output.
module four_value_frame_with_crc16 (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_value_a,
    input  wire logic [15:0] s_value_b,
    input  wire logic [15:0] s_value_c,
    input  wire logic [15:0] s_value_d,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_frame_byte,
    output logic             m_last_byte
);

    logic               buf_valid;
    logic               buf_take;
    fvf_pkg::fvf_item_t buf_item;

    fvf_in_buf u_in_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_value_a (s_value_a),
        .s_value_b (s_value_b),
        .s_value_c (s_value_c),
        .s_value_d (s_value_d),
        .buf_valid (buf_valid),
        .buf_take  (buf_take),
        .buf_item  (buf_item)
    );

    fvf_serializer u_serializer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .buf_valid    (buf_valid),
        .buf_take     (buf_take),
        .buf_item     (buf_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_last_byte  (m_last_byte)
    );

endmodule

`default_nettype wire

### hw/rtl/fvf_checker.sv
`default_nettype none

// Port-level checks on frame framing and item bookkeeping.
module fvf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_frame_byte,
    input wire logic        m_last_byte
);

    logic [3:0] byte_cnt_reg;
    logic [1:0] pending_reg;
    logic       in_xfer;
    logic       out_xfer;
    logic       frame_done;

    assign in_xfer    = s_valid && s_ready;
    assign out_xfer   = m_valid && m_ready;
    assign frame_done = out_xfer && m_last_byte;

    // Count bytes within the current frame.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_cnt_reg <= '0;
        end else if (out_xfer) begin
            byte_cnt_reg <= m_last_byte ? 4'd0 : byte_cnt_reg + 4'd1;
        end
    end

    // Count items accepted whose frame has not finished.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else if (in_xfer && !frame_done) begin
            pending_reg <= pending_reg + 2'd1;
        end else if (!in_xfer && frame_done) begin
            pending_reg <= pending_reg - 2'd1;
        end
    end

    // A stalled output byte holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_byte) && $stable(m_last_byte))
        else $error("output changed while stalled");

    // The last flag marks exactly the tenth byte of every frame.
    a_last_tenth: assert property (@(posedge aclk) disable iff (!aresetn)
        out_xfer |-> (m_last_byte == (byte_cnt_reg == 4'd9)))
        else $error("last flag not on tenth byte");

    // No byte appears without an accepted item behind it.
    a_no_orphan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pending_reg != 2'd0))
        else $error("output without pending item");

    // At most three items are in flight.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |-> (pending_reg != 2'd3))
        else $error("too many items in flight");

endmodule

bind four_value_frame_with_crc16 fvf_checker u_fvf_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_frame_byte (m_frame_byte),
    .m_last_byte  (m_last_byte)
);

`default_nettype wire

### tb/tb_four_value_frame_with_crc16.sv
`timescale 1ns / 1ps

module tb_four_value_frame_with_crc16;

    // Frame shape and CRC-16/MODBUS constants.
    localparam int          FrameBytes    = 10;
    localparam logic [15:0] CrcSeed       = 16'hFFFF;
    localparam logic [15:0] CrcPolyRefl   = 16'hA001;

    // Run shape.
    localparam int DirectedRows  = 14;
    localparam int HoldOffItems  = 8;
    localparam int HoldOffCycles = 150;
    localparam int RandomItems   = 390;
    localparam int SteadyItems   = 50;
    localparam int DrainCycles   = 8;
    localparam int CycleLimit    = 200000;
    localparam int MaxPrinted    = 20;

    // One expected output byte.
    typedef struct {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    // One directed stimulus row; pin marks rows whose CRC is typed in.
    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] d;
        logic        pin;
        logic [15:0] crc;
    } vec_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_value_a;
    logic [15:0] s_value_b;
    logic [15:0] s_value_c;
    logic [15:0] s_value_d;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_frame_byte;
    logic        m_last_byte;

    // Typed-in CRC that travels with the payload of a pinned directed row.
    logic        pin_crc_en;
    logic [15:0] pin_crc_val;

    frame_byte_t bytes_due[$];
    vec_row_t    directed_rows[DirectedRows];

    bit src_gaps_en;
    bit sink_stalls_en;
    bit hold_off_req;

    int error_count;
    int items_accepted;
    int bytes_checked;
    int cycle_count;

    four_value_frame_with_crc16 u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value_a    (s_value_a),
        .s_value_b    (s_value_b),
        .s_value_c    (s_value_c),
        .s_value_d    (s_value_d),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_byte (m_frame_byte),
        .m_last_byte  (m_last_byte)
    );

    // Free-running clock.
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Prints one line per failure, up to a cap, and counts every one.
    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= MaxPrinted) begin
            $display("%0t: mismatch: %s", $realtime, msg);
        end
    endtask

    // Bit-serial CRC over the whole 64-bit payload, value_a bit 0 first.
    function automatic logic [15:0] modbus_crc16(input logic [63:0] payload);
        logic [15:0] crc;
        logic        fb;
        crc = CrcSeed;
        for (int i = 0; i < 64; i++) begin
            fb  = crc[0] ^ payload[i];
            crc = crc >> 1;
            if (fb) begin
                crc = crc ^ CrcPolyRefl;
            end
        end
        return crc;
    endfunction

    // Queues the ten bytes that one accepted item must produce.
    function automatic void push_frame(input logic [15:0] a, input logic [15:0] b,
                                       input logic [15:0] c, input logic [15:0] d,
                                       input logic pin, input logic [15:0] pinned);
        logic [63:0] payload;
        logic [15:0] crc;
        frame_byte_t fb;
        payload = {d, c, b, a};
        crc = pin ? pinned : modbus_crc16(payload);
        for (int k = 0; k < FrameBytes; k++) begin
            if (k < 8) begin
                fb.data = payload[8*k +: 8];
            end else begin
                fb.data = crc[8*(k-8) +: 8];
            end
            fb.last = (k == FrameBytes - 1);
            bytes_due.push_back(fb);
        end
    endfunction

    // Full-range random values half the time, corner patterns the other half.
    function automatic logic [15:0] pick_value();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0: v = 16'h0000;
            1: v = 16'hFFFF;
            2: v = 16'h0001 << $urandom_range(0, 15);
            3: v = ~(16'h0001 << $urandom_range(0, 15));
            default: v = 16'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    // Offers one item starting at a falling edge and returns at the falling
    // edge after its transfer.
    task automatic offer_item(input logic [15:0] a, input logic [15:0] b,
                              input logic [15:0] c, input logic [15:0] d,
                              input logic pin, input logic [15:0] pinned);
        if (src_gaps_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_value_a   <= a;
        s_value_b   <= b;
        s_value_c   <= c;
        s_value_d   <= d;
        pin_crc_en  <= pin;
        pin_crc_val <= pinned;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic offer_random_item();
        offer_item(pick_value(), pick_value(), pick_value(), pick_value(), 1'b0, 16'h0000);
    endtask

    // Records each input transfer and checks each output transfer.
    always @(posedge aclk) begin : scoreboard
        frame_byte_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                push_frame(s_value_a, s_value_b, s_value_c, s_value_d,
                           pin_crc_en, pin_crc_val);
                items_accepted++;
            end
            if (m_valid && m_ready) begin
                if (bytes_due.size() == 0) begin
                    report_error($sformatf("byte %02h with nothing expected", m_frame_byte));
                end else begin
                    want = bytes_due.pop_front();
                    if (m_frame_byte !== want.data) begin
                        report_error($sformatf("frame_byte %02h, want %02h",
                                               m_frame_byte, want.data));
                    end
                    if (m_last_byte !== want.last) begin
                        report_error($sformatf("last_byte %0b, want %0b",
                                               m_last_byte, want.last));
                    end
                    bytes_checked++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[four_value_frame_with_crc16] ERROR");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin : sink
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HoldOffCycles) @(negedge aclk);
                hold_off_req = 1'b0;
                m_ready <= 1'b1;
            end else if (sink_stalls_en && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Stimulus sequence.
    initial begin : stimulus
        vec_row_t row;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_value_a      = 16'h0000;
        s_value_b      = 16'h0000;
        s_value_c      = 16'h0000;
        s_value_d      = 16'h0000;
        pin_crc_en     = 1'b0;
        pin_crc_val    = 16'h0000;
        src_gaps_en    = 1'b0;
        sink_stalls_en = 1'b0;
        hold_off_req   = 1'b0;

        // Corners and byte-order checks. A leading 0xFFFF cancels the all-ones
        // CRC start, and zero bytes after it keep the CRC at zero.
        directed_rows = '{
            '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000},
            '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000},
            '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
            '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, 16'h0000},
            '{16'h0201, 16'h0403, 16'h0605, 16'h0807, 1'b0, 16'h0000},
            '{16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b0, 16'h0000},
            '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 16'h0000},
            '{16'h00FF, 16'hFF00, 16'h00FF, 16'hFF00, 1'b0, 16'h0000},
            '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0, 16'h0000},
            '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, 16'h0000},
            '{16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1'b0, 16'h0000},
            '{16'h7FFF, 16'h8001, 16'hFFFE, 16'h0100, 1'b0, 16'h0000},
            '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, 16'h0000},
            '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 16'h0000}
        };

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed rows, back to back with the receiver always ready.
        for (int i = 0; i < DirectedRows; i++) begin
            row = directed_rows[i];
            offer_item(row.a, row.b, row.c, row.d, row.pin, row.crc);
        end

        // Sender pauses until every frame has drained.
        s_valid <= 1'b0;
        while (bytes_due.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        @(negedge aclk);

        // Long receiver hold-off while the sender keeps offering items.
        hold_off_req = 1'b1;
        for (int i = 0; i < HoldOffItems; i++) begin
            offer_random_item();
        end

        // Random items with idling on both sides.
        src_gaps_en    = 1'b1;
        sink_stalls_en = 1'b1;
        for (int i = 0; i < RandomItems; i++) begin
            offer_random_item();
        end

        // Closing stretch at full rate.
        src_gaps_en    = 1'b0;
        sink_stalls_en = 1'b0;
        for (int i = 0; i < SteadyItems; i++) begin
            offer_random_item();
        end
        s_valid <= 1'b0;

        // Drain, then give any stray bytes time to show up.
        while (bytes_due.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        $display("Sent %0d items and checked %0d frame bytes, over corner values,",
                 items_accepted, bytes_checked);
        $display("a long output hold-off and random idling on both channels.");
        if (error_count == 0) begin
            $display("[four_value_frame_with_crc16] OK");
        end else begin
            $display("%0d mismatches", error_count);
            $display("[four_value_frame_with_crc16] ERROR");
        end
        $finish;
    end

endmodule
